// ===== hw/rtl/mnc_pkg.sv =====
// markov note chain: shared types and command codes
// used by mnc_seq and markov_note_chain_unit; no dependencies
`default_nettype none

package mnc_pkg;

    typedef enum logic [2:0] {
        CMD_LEARN   = 3'd0,
        CMD_ADVANCE = 3'd1,
        CMD_NEAREST = 3'd2,
        CMD_FORGET  = 3'd3,
        CMD_CLEAR   = 3'd4
    } cmd_t;

    typedef enum logic [5:0] {
        ST_IDLE,
        ST_FIND_RD,
        ST_FIND_CMP,
        ST_L_EDGE,
        ST_L_CNT,
        ST_L_ESCAN_RD,
        ST_L_ESCAN_CMP,
        ST_L_BUB_RD,
        ST_L_BUB_CMP,
        ST_L_SET,
        ST_A_USED_RD,
        ST_A_USED,
        ST_A_RAND,
        ST_A_SUM_RD,
        ST_A_SUM_ADD,
        ST_A_THR,
        ST_A_THR2,
        ST_A_PICK_RD,
        ST_A_PICK_CMP,
        ST_A_TGT_RD,
        ST_A_TGT,
        ST_N_RD,
        ST_N_CMP,
        ST_F_NRD,
        ST_F_NWR,
        ST_F_ROW_RD,
        ST_F_ROW_WR,
        ST_F_DEC,
        ST_F_C_RD,
        ST_F_C_CNT,
        ST_F_C_ERD,
        ST_F_C_ECMP,
        ST_F_END,
        ST_FIN,
        ST_FIN2
    } seq_state_t;

    // one accepted request, randomness already saturated to +-256
    typedef struct packed {
        cmd_t               cmd;
        logic [6:0]         note;
        logic signed [9:0]  r;
        logic [15:0]        rand_pick;
        logic [15:0]        rand_skip;
        logic [15:0]        rand_node;
    } mnc_req_t;

    typedef struct packed {
        logic       done;
        logic [6:0] note;
        logic       has;
    } mnc_res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/mnc_ram.sv =====
// markov note chain: generic single-write, single-read ram with registered read
// no dependencies
`default_nettype none

module mnc_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  wire logic                 aclk,
    input  wire logic                 we,
    input  wire logic [$clog2(D)-1:0] waddr,
    input  wire logic [W-1:0]         wdata,
    input  wire logic [$clog2(D)-1:0] raddr,
    output logic      [W-1:0]         rdata
);

    logic [W-1:0] mem [D];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== hw/rtl/mnc_seq.sv =====
// markov note chain: command sequencer over node, edge-count and edge memories
// depends on mnc_pkg and mnc_ram
`default_nettype none

module mnc_seq #(
    parameter int MAX_NODES  = 128,
    parameter int MAX_EDGES  = 16,
    parameter int COUNT_BITS = 16,
    parameter int RAND_BITS  = 16
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire mnc_pkg::mnc_req_t req,
    input  wire logic             ack,
    output mnc_pkg::mnc_res_t     res
);
    import mnc_pkg::*;

    localparam int NW    = $clog2(MAX_NODES);
    localparam int TW    = $clog2(MAX_NODES + 1);
    localparam int UW    = $clog2(MAX_EDGES + 1);
    localparam int CELLS = MAX_NODES * MAX_EDGES;
    localparam int AW    = $clog2(CELLS);
    localparam int CB    = COUNT_BITS;
    localparam int SW    = COUNT_BITS + UW;
    localparam int EWD   = 7 + COUNT_BITS;
    localparam int RW    = RAND_BITS;
    localparam int PW    = RW + 9;
    localparam int PRW   = RW + SW;
    localparam int RTW   = RW + TW;

    function automatic logic [AW-1:0] ea(input logic [NW-1:0] sl, input logic [UW-1:0] ee);
        ea = AW'(sl) * AW'(MAX_EDGES) + AW'(ee);
    endfunction

    seq_state_t     state_reg, state_next;
    logic [TW-1:0]  total_reg, total_next;
    logic [NW-1:0]  cur_reg, cur_next;
    logic           valid_reg, valid_next;
    logic [6:0]     cnote_reg, cnote_next;
    logic [TW-1:0]  idx_reg, idx_next;
    logic [UW-1:0]  e_reg, e_next;
    logic [UW-1:0]  k_reg, k_next;
    logic [UW-1:0]  cnt_reg, cnt_next;
    logic [NW-1:0]  s_reg, s_next;
    logic [NW-1:0]  best_reg, best_next;
    logic [7:0]     bestd_reg, bestd_next;
    logic [CB-1:0]  w_reg, w_next;
    logic [SW-1:0]  sum_reg, sum_next;
    logic [SW-1:0]  thr_reg, thr_next;
    logic [PRW-1:0] prod_reg, prod_next;
    logic [6:0]     note_reg, note_next;
    logic [NW-1:0]  gone_reg, gone_next;
    logic [6:0]     gnote_reg, gnote_next;
    logic [AW-1:0]  j_reg, j_next;
    logic [AW-1:0]  jend_reg, jend_next;
    logic           fadv_reg, fadv_next;

    logic           n_we, u_we, e_we;
    logic [NW-1:0]  n_waddr, n_raddr, u_waddr, u_raddr;
    logic [6:0]     n_wdata, n_rdata;
    logic [UW-1:0]  u_wdata, u_rdata;
    logic [AW-1:0]  e_waddr, e_raddr;
    logic [EWD-1:0] e_wdata, e_rdata;

    logic [6:0]     e_tgt;
    logic [CB-1:0]  e_wt;
    logic [CB-1:0]  w_inc;
    logic [6:0]     note_gap;
    logic [RW-1:0]  rp, rs, rn;
    logic [9:0]     r_up, r_dn;
    logic [PW-1:0]  jump_lhs, jump_rhs, skip_lhs, skip_rhs;
    logic [RTW-1:0] rprod;
    logic [TW-1:0]  rslot;
    logic [SW-1:0]  acc_new;

    mnc_ram #(.W(7), .D(MAX_NODES)) u_node_ram (
        .aclk(aclk), .we(n_we), .waddr(n_waddr), .wdata(n_wdata),
        .raddr(n_raddr), .rdata(n_rdata)
    );

    mnc_ram #(.W(UW), .D(MAX_NODES)) u_used_ram (
        .aclk(aclk), .we(u_we), .waddr(u_waddr), .wdata(u_wdata),
        .raddr(u_raddr), .rdata(u_rdata)
    );

    mnc_ram #(.W(EWD), .D(CELLS)) u_edge_ram (
        .aclk(aclk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
        .raddr(e_raddr), .rdata(e_rdata)
    );

    assign e_tgt    = e_rdata[EWD-1:CB];
    assign e_wt     = e_rdata[CB-1:0];
    assign w_inc    = (&e_wt) ? e_wt : e_wt + 1'b1;
    assign note_gap = (n_rdata > note_reg) ? n_rdata - note_reg : note_reg - n_rdata;

    assign rp = RW'(req.rand_pick);
    assign rs = RW'(req.rand_skip);
    assign rn = RW'(req.rand_node);

    // jump chances for dead end and skip
    assign r_up     = req.r + 10'sd128;
    assign r_dn     = req.r - 10'sd128;
    assign jump_lhs = PW'(rs) * PW'(384);
    assign jump_rhs = {r_up[8:0], {RW{1'b0}}};
    assign skip_lhs = PW'({rs, 7'b0});
    assign skip_rhs = {1'b0, r_dn[7:0], {RW{1'b0}}};

    assign rprod   = RTW'(rn) * RTW'(total_reg);
    assign rslot   = (TW'(rprod >> RW) >= total_reg) ? total_reg - 1'b1 : TW'(rprod >> RW);
    assign acc_new = sum_reg + SW'(e_wt);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            total_reg <= '0;
            cur_reg   <= '0;
            valid_reg <= 1'b0;
            cnote_reg <= '0;
        end else begin
            state_reg <= state_next;
            total_reg <= total_next;
            cur_reg   <= cur_next;
            valid_reg <= valid_next;
            cnote_reg <= cnote_next;
        end
        idx_reg   <= idx_next;
        e_reg     <= e_next;
        k_reg     <= k_next;
        cnt_reg   <= cnt_next;
        s_reg     <= s_next;
        best_reg  <= best_next;
        bestd_reg <= bestd_next;
        w_reg     <= w_next;
        sum_reg   <= sum_next;
        thr_reg   <= thr_next;
        prod_reg  <= prod_next;
        note_reg  <= note_next;
        gone_reg  <= gone_next;
        gnote_reg <= gnote_next;
        j_reg     <= j_next;
        jend_reg  <= jend_next;
        fadv_reg  <= fadv_next;
    end

    always_comb begin
        state_next = state_reg;
        total_next = total_reg;
        cur_next   = cur_reg;
        valid_next = valid_reg;
        cnote_next = cnote_reg;
        idx_next   = idx_reg;
        e_next     = e_reg;
        k_next     = k_reg;
        cnt_next   = cnt_reg;
        s_next     = s_reg;
        best_next  = best_reg;
        bestd_next = bestd_reg;
        w_next     = w_reg;
        sum_next   = sum_reg;
        thr_next   = thr_reg;
        prod_next  = prod_reg;
        note_next  = note_reg;
        gone_next  = gone_reg;
        gnote_next = gnote_reg;
        j_next     = j_reg;
        jend_next  = jend_reg;
        fadv_next  = fadv_reg;

        n_we    = 1'b0;
        n_waddr = NW'(total_reg);
        n_wdata = note_reg;
        n_raddr = cur_reg;
        u_we    = 1'b0;
        u_waddr = NW'(total_reg);
        u_wdata = '0;
        u_raddr = cur_reg;
        e_we    = 1'b0;
        e_waddr = ea(cur_reg, e_reg);
        e_wdata = e_rdata;
        e_raddr = ea(cur_reg, e_reg);

        res.done = 1'b0;
        res.note = valid_reg ? n_rdata : 7'd0;
        res.has  = valid_reg;

        case (state_reg)
            ST_IDLE: begin
                note_next  = req.note;
                idx_next   = '0;
                bestd_next = 8'hff;
                fadv_next  = 1'b0;
                if (start) begin
                    case (req.cmd)
                        CMD_LEARN: begin
                            if (valid_reg && cnote_reg == req.note) begin
                                state_next = ST_FIN;
                            end else begin
                                state_next = ST_FIND_RD;
                            end
                        end
                        CMD_ADVANCE: begin
                            if (!valid_reg) begin
                                if (total_reg != '0) begin
                                    cur_next   = '0;
                                    valid_next = 1'b1;
                                end
                                state_next = ST_FIN;
                            end else begin
                                state_next = ST_A_USED_RD;
                            end
                        end
                        CMD_NEAREST: begin
                            state_next = (total_reg == '0) ? ST_FIN : ST_N_RD;
                        end
                        CMD_FORGET: begin
                            if (!valid_reg || total_reg == '0) begin
                                state_next = ST_FIN;
                            end else begin
                                gone_next  = cur_reg;
                                gnote_next = cnote_reg;
                                idx_next   = TW'(cur_reg);
                                state_next = ST_F_NRD;
                            end
                        end
                        CMD_CLEAR: begin
                            total_next = '0;
                            cur_next   = '0;
                            valid_next = 1'b0;
                            state_next = ST_FIN;
                        end
                        default: begin
                            state_next = ST_FIN;
                        end
                    endcase
                end
            end

            // linear search of node notes, shared by learn and advance
            ST_FIND_RD: begin
                n_raddr = NW'(idx_reg);
                if (idx_reg == total_reg) begin
                    if (fadv_reg) begin
                        state_next = ST_FIN;
                    end else if (total_reg >= TW'(MAX_NODES)) begin
                        state_next = ST_FIN;
                    end else begin
                        n_we       = 1'b1;
                        u_we       = 1'b1;
                        s_next     = NW'(total_reg);
                        total_next = total_reg + 1'b1;
                        state_next = valid_reg ? ST_L_EDGE : ST_L_SET;
                    end
                end else begin
                    state_next = ST_FIND_CMP;
                end
            end
            ST_FIND_CMP: begin
                if (n_rdata == note_reg) begin
                    if (fadv_reg) begin
                        cur_next   = NW'(idx_reg);
                        state_next = ST_FIN;
                    end else begin
                        s_next     = NW'(idx_reg);
                        state_next = valid_reg ? ST_L_EDGE : ST_L_SET;
                    end
                end else begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_FIND_RD;
                end
            end

            // learn: bump or append the edge from the current node
            ST_L_EDGE: begin
                state_next = ST_L_CNT;
            end
            ST_L_CNT: begin
                cnt_next   = u_rdata;
                e_next     = '0;
                state_next = ST_L_ESCAN_RD;
            end
            ST_L_ESCAN_RD: begin
                if (e_reg == cnt_reg) begin
                    if (cnt_reg < UW'(MAX_EDGES)) begin
                        e_we    = 1'b1;
                        e_waddr = ea(cur_reg, cnt_reg);
                        e_wdata = {note_reg, CB'(1)};
                        u_we    = 1'b1;
                        u_waddr = cur_reg;
                        u_wdata = cnt_reg + 1'b1;
                    end
                    state_next = ST_L_SET;
                end else begin
                    state_next = ST_L_ESCAN_CMP;
                end
            end
            ST_L_ESCAN_CMP: begin
                if (e_tgt == note_reg) begin
                    w_next     = w_inc;
                    state_next = ST_L_BUB_RD;
                end else begin
                    e_next     = e_reg + 1'b1;
                    state_next = ST_L_ESCAN_RD;
                end
            end
            ST_L_BUB_RD: begin
                e_raddr = ea(cur_reg, e_reg - 1'b1);
                if (e_reg == '0) begin
                    e_we       = 1'b1;
                    e_wdata    = {note_reg, w_reg};
                    state_next = ST_L_SET;
                end else begin
                    state_next = ST_L_BUB_CMP;
                end
            end
            ST_L_BUB_CMP: begin
                e_we = 1'b1;
                if (e_wt < w_reg) begin
                    e_wdata    = e_rdata;
                    e_next     = e_reg - 1'b1;
                    state_next = ST_L_BUB_RD;
                end else begin
                    e_wdata    = {note_reg, w_reg};
                    state_next = ST_L_SET;
                end
            end
            ST_L_SET: begin
                cur_next   = s_reg;
                valid_next = 1'b1;
                state_next = ST_FIN;
            end

            // advance
            ST_A_USED_RD: begin
                state_next = ST_A_USED;
            end
            ST_A_USED: begin
                cnt_next = u_rdata;
                e_next   = '0;
                sum_next = '0;
                if (u_rdata == '0) begin
                    if (req.r < -10'sd128) begin
                        state_next = ST_FIN;
                    end else if (jump_lhs < jump_rhs) begin
                        state_next = ST_A_RAND;
                    end else begin
                        state_next = ST_FIN;
                    end
                end else if (req.r > 10'sd128 && skip_lhs < skip_rhs) begin
                    state_next = ST_A_RAND;
                end else if (req.r > -10'sd231) begin
                    state_next = ST_A_SUM_RD;
                end else begin
                    state_next = ST_A_TGT_RD;
                end
            end
            ST_A_RAND: begin
                cur_next   = NW'(rslot);
                state_next = ST_FIN;
            end
            ST_A_SUM_RD: begin
                state_next = (e_reg == cnt_reg) ? ST_A_THR : ST_A_SUM_ADD;
            end
            ST_A_SUM_ADD: begin
                sum_next   = acc_new;
                e_next     = e_reg + 1'b1;
                state_next = ST_A_SUM_RD;
            end
            ST_A_THR: begin
                prod_next  = PRW'(rp) * PRW'(sum_reg);
                state_next = ST_A_THR2;
            end
            ST_A_THR2: begin
                thr_next   = SW'(prod_reg >> RW) + SW'(|prod_reg[RW-1:0]);
                sum_next   = '0;
                e_next     = '0;
                state_next = ST_A_PICK_RD;
            end
            ST_A_PICK_RD: begin
                if (e_reg == cnt_reg) begin
                    e_next     = cnt_reg - 1'b1;
                    state_next = ST_A_TGT_RD;
                end else begin
                    state_next = ST_A_PICK_CMP;
                end
            end
            ST_A_PICK_CMP: begin
                sum_next = acc_new;
                if (thr_reg <= acc_new) begin
                    state_next = ST_A_TGT_RD;
                end else begin
                    e_next     = e_reg + 1'b1;
                    state_next = ST_A_PICK_RD;
                end
            end
            ST_A_TGT_RD: begin
                state_next = ST_A_TGT;
            end
            ST_A_TGT: begin
                note_next  = e_tgt;
                idx_next   = '0;
                fadv_next  = 1'b1;
                state_next = ST_FIND_RD;
            end

            // nearest note search
            ST_N_RD: begin
                n_raddr = NW'(idx_reg);
                if (idx_reg == total_reg) begin
                    cur_next   = best_reg;
                    valid_next = 1'b1;
                    state_next = ST_FIN;
                end else begin
                    state_next = ST_N_CMP;
                end
            end
            ST_N_CMP: begin
                if ({1'b0, note_gap} < bestd_reg) begin
                    bestd_next = {1'b0, note_gap};
                    best_next  = NW'(idx_reg);
                end
                idx_next   = idx_reg + 1'b1;
                state_next = ST_N_RD;
            end

            // forget: shift node rows down
            ST_F_NRD: begin
                n_raddr = NW'(idx_reg + 1'b1);
                u_raddr = NW'(idx_reg + 1'b1);
                if ((TW + 1)'(idx_reg) + 1'b1 >= (TW + 1)'(total_reg)) begin
                    j_next     = AW'(gone_reg) * AW'(MAX_EDGES);
                    jend_next  = AW'(total_reg - 1'b1) * AW'(MAX_EDGES);
                    state_next = ST_F_ROW_RD;
                end else begin
                    state_next = ST_F_NWR;
                end
            end
            ST_F_NWR: begin
                n_we       = 1'b1;
                n_waddr    = NW'(idx_reg);
                n_wdata    = n_rdata;
                u_we       = 1'b1;
                u_waddr    = NW'(idx_reg);
                u_wdata    = u_rdata;
                idx_next   = idx_reg + 1'b1;
                state_next = ST_F_NRD;
            end
            ST_F_ROW_RD: begin
                e_raddr = j_reg + AW'(MAX_EDGES);
                state_next = (j_reg >= jend_reg) ? ST_F_DEC : ST_F_ROW_WR;
            end
            ST_F_ROW_WR: begin
                e_we       = 1'b1;
                e_waddr    = j_reg;
                e_wdata    = e_rdata;
                j_next     = j_reg + 1'b1;
                state_next = ST_F_ROW_RD;
            end
            ST_F_DEC: begin
                total_next = total_reg - 1'b1;
                idx_next   = '0;
                state_next = ST_F_C_RD;
            end
            // forget: drop edges to the removed note from every list
            ST_F_C_RD: begin
                u_raddr    = NW'(idx_reg);
                state_next = (idx_reg == total_reg) ? ST_F_END : ST_F_C_CNT;
            end
            ST_F_C_CNT: begin
                cnt_next   = u_rdata;
                e_next     = '0;
                k_next     = '0;
                state_next = ST_F_C_ERD;
            end
            ST_F_C_ERD: begin
                e_raddr = ea(NW'(idx_reg), e_reg);
                if (e_reg == cnt_reg) begin
                    u_we       = 1'b1;
                    u_waddr    = NW'(idx_reg);
                    u_wdata    = k_reg;
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_F_C_RD;
                end else begin
                    state_next = ST_F_C_ECMP;
                end
            end
            ST_F_C_ECMP: begin
                if (e_tgt != gnote_reg) begin
                    e_we    = 1'b1;
                    e_waddr = ea(NW'(idx_reg), k_reg);
                    e_wdata = e_rdata;
                    k_next  = k_reg + 1'b1;
                end
                e_next     = e_reg + 1'b1;
                state_next = ST_F_C_ERD;
            end
            ST_F_END: begin
                if (total_reg == '0) begin
                    valid_next = 1'b0;
                    cur_next   = '0;
                    state_next = ST_FIN;
                end else begin
                    note_next  = 7'(gone_reg);
                    idx_next   = '0;
                    bestd_next = 8'hff;
                    state_next = ST_N_RD;
                end
            end

            // read the current note and hold the result until taken
            ST_FIN: begin
                state_next = ST_FIN2;
            end
            ST_FIN2: begin
                res.done = 1'b1;
                if (ack) begin
                    cnote_next = n_rdata;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/markov_note_chain_unit.sv =====
// markov note chain: top level with request/result handshakes and result register
// depends on mnc_pkg, mnc_seq and mnc_ram
//
// usage
// - one request on the s_ channel carries a command (learn, advance, set nearest
//   note, forget current, clear), a note and three random fractions; each request
//   gives exactly one result on the m_ channel: the current note and a flag
//   that a current node exists
// - requests are taken one at a time; s_ready is low from acceptance until the
//   result has moved into the output register
// - latency depends on the command and the table fill (the number of nodes, and the
//   edges on the current list); every access goes through the single-read-port memories
// - the result register holds one result; while the receiver stalls, the
//   finished sequencer waits and the next request stays blocked
// - reset empties the chain: no nodes, no current note; the memories hold no
//   valid data and need no clearing pass
`default_nettype none

module markov_note_chain_unit #(
    parameter int MAX_NODES  = 128,
    parameter int MAX_EDGES  = 16,
    parameter int COUNT_BITS = 16,
    parameter int RAND_BITS  = 16
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [2:0]        s_cmd,
    input  wire logic [6:0]        s_note,
    input  wire logic signed [9:0] s_randomness,
    input  wire logic [15:0]       s_rand_pick,
    input  wire logic [15:0]       s_rand_skip,
    input  wire logic [15:0]       s_rand_node,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [6:0]             m_current_note,
    output logic                   m_has_current
);
    import mnc_pkg::*;

    mnc_req_t          req_reg, req_next;
    logic              busy_reg, busy_next;
    logic              start_reg;
    logic              m_valid_reg, m_valid_next;
    logic [6:0]        m_note_reg;
    logic              m_has_reg;
    logic              accept;
    logic              ack;
    logic signed [9:0] r_sat;
    mnc_res_t          res;

    assign s_ready = !busy_reg;
    assign accept  = s_valid && s_ready;

    // randomness clipped to -1..+1 in 1/256 units
    assign r_sat = (s_randomness > 10'sd256)  ? 10'sd256 :
                   (s_randomness < -10'sd256) ? -10'sd256 : s_randomness;

    // result moves on when the output register is empty or being drained
    assign ack = res.done && (!m_valid_reg || m_ready);

    always_comb begin
        req_next = req_reg;
        if (accept) begin
            req_next.cmd       = cmd_t'(s_cmd);
            req_next.note      = s_note;
            req_next.r         = r_sat;
            req_next.rand_pick = s_rand_pick;
            req_next.rand_skip = s_rand_skip;
            req_next.rand_node = s_rand_node;
        end
        busy_next = busy_reg;
        if (accept) begin
            busy_next = 1'b1;
        end else if (ack) begin
            busy_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (ack) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            start_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            busy_reg    <= busy_next;
            start_reg   <= accept;
            m_valid_reg <= m_valid_next;
        end
        req_reg <= req_next;
        if (ack) begin
            m_note_reg <= res.note;
            m_has_reg  <= res.has;
        end
    end

    mnc_seq #(
        .MAX_NODES (MAX_NODES),
        .MAX_EDGES (MAX_EDGES),
        .COUNT_BITS(COUNT_BITS),
        .RAND_BITS (RAND_BITS)
    ) u_seq (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (start_reg),
        .req    (req_reg),
        .ack    (ack),
        .res    (res)
    );

    assign m_valid        = m_valid_reg;
    assign m_current_note = m_note_reg;
    assign m_has_current  = m_has_reg;

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
// testbench for markov_note_chain_unit: random and directed command streams
// with a scoreboard class that predicts every result; depends on mnc_pkg
`timescale 1ns / 100ps

module tb_top;
    import mnc_pkg::*;

    // expected current note and flag for one request
    typedef struct {
        bit [6:0] note;
        bit       has;
    } chain_result_t;

    // tracks the chain tables and checks each result in order
    class chain_scoreboard;
        bit [6:0]    slot_note[128];
        int          slot_count;
        int          cur_slot;
        bit          cur_ok;
        bit [6:0]    succ_note[128][16];
        int unsigned succ_cnt[128][16];
        int          succ_len[128];
        chain_result_t pending[$];
        int          errors;

        function void wipe();
            slot_count = 0;
            cur_slot   = 0;
            cur_ok     = 0;
            foreach (succ_len[i]) succ_len[i] = 0;
        endfunction

        function int slot_of(int n);
            for (int i = 0; i < slot_count; i++)
                if (slot_note[i] == n) return i;
            return -1;
        endfunction

        function int pick_slot(longint unsigned rn);
            longint unsigned idx;
            idx = (rn * slot_count) >> 16;
            if (slot_count == 0) return 0;
            if (idx >= slot_count) idx = slot_count - 1;
            return int'(idx);
        endfunction

        function void go_nearest(int n);
            int best;
            int bestd;
            int d;
            best  = 0;
            bestd = 1000;
            if (slot_count == 0) return;
            for (int i = 0; i < slot_count; i++) begin
                d = (slot_note[i] > n) ? slot_note[i] - n : n - slot_note[i];
                if (d < bestd) begin
                    bestd = d;
                    best  = i;
                end
            end
            cur_slot = best;
            cur_ok   = 1;
        endfunction

        function void do_learn(int n);
            int s;
            int e;
            int c;
            int unsigned w;
            bit [6:0] t;
            s = slot_of(n);
            if (cur_ok && slot_note[cur_slot] == n) return;
            if (s < 0) begin
                if (slot_count >= 128) return;
                s = slot_count;
                slot_note[s] = 7'(n);
                succ_len[s]  = 0;
                slot_count++;
            end
            if (cur_ok) begin
                c = succ_len[cur_slot];
                for (e = 0; e < c; e++)
                    if (succ_note[cur_slot][e] == n) break;
                if (e < c) begin
                    if (succ_cnt[cur_slot][e] < 65535) succ_cnt[cur_slot][e]++;
                    // bubble ahead of smaller counts, ties keep order
                    while (e > 0 && succ_cnt[cur_slot][e-1] < succ_cnt[cur_slot][e]) begin
                        w = succ_cnt[cur_slot][e];
                        t = succ_note[cur_slot][e];
                        succ_cnt[cur_slot][e]    = succ_cnt[cur_slot][e-1];
                        succ_note[cur_slot][e]   = succ_note[cur_slot][e-1];
                        succ_cnt[cur_slot][e-1]  = w;
                        succ_note[cur_slot][e-1] = t;
                        e--;
                    end
                end else if (c < 16) begin
                    succ_note[cur_slot][c] = 7'(n);
                    succ_cnt[cur_slot][c]  = 1;
                    succ_len[cur_slot]     = c + 1;
                end
            end
            cur_slot = s;
            cur_ok   = 1;
        endfunction

        function void do_advance(int r, longint unsigned rp, longint unsigned rs,
                                 longint unsigned rn);
            int c;
            int pick;
            int s;
            longint unsigned total;
            longint unsigned acc;
            longint unsigned thr;
            if (!cur_ok) begin
                if (slot_count > 0) begin
                    cur_slot = 0;
                    cur_ok   = 1;
                end
                return;
            end
            c = succ_len[cur_slot];
            if (c == 0) begin
                // dead end: maybe jump to a random slot
                if (r < -128) return;
                if (rs * 384 < (longint'(r + 128) << 16)) cur_slot = pick_slot(rn);
                return;
            end
            pick = 0;
            if (r > -231) begin
                total = 0;
                acc   = 0;
                for (int e = 0; e < c; e++) total += succ_cnt[cur_slot][e];
                thr  = (rp * total + 65535) >> 16;
                pick = c - 1;
                for (int e = 0; e < c; e++) begin
                    acc += succ_cnt[cur_slot][e];
                    if (thr <= acc) begin
                        pick = e;
                        break;
                    end
                end
            end
            if (r > 128 && rs * 128 < (longint'(r - 128) << 16)) begin
                cur_slot = pick_slot(rn);
                return;
            end
            s = slot_of(succ_note[cur_slot][pick]);
            if (s >= 0) cur_slot = s;
        endfunction

        function void do_forget();
            int gone;
            int n;
            int k;
            if (!cur_ok || slot_count == 0) return;
            gone = cur_slot;
            n    = slot_note[gone];
            for (int i = gone; i + 1 < slot_count; i++) begin
                slot_note[i] = slot_note[i+1];
                succ_len[i]  = succ_len[i+1];
                succ_note[i] = succ_note[i+1];
                succ_cnt[i]  = succ_cnt[i+1];
            end
            slot_count--;
            for (int i = 0; i < slot_count; i++) begin
                k = 0;
                for (int e = 0; e < succ_len[i]; e++) begin
                    if (succ_note[i][e] != n) begin
                        succ_note[i][k] = succ_note[i][e];
                        succ_cnt[i][k]  = succ_cnt[i][e];
                        k++;
                    end
                end
                succ_len[i] = k;
            end
            if (slot_count == 0) begin
                cur_ok   = 0;
                cur_slot = 0;
            end else begin
                go_nearest(gone);
            end
        endfunction

        function void note_request(bit [2:0] cmd, bit [6:0] note, bit [9:0] r_raw,
                                   bit [15:0] rp, bit [15:0] rs, bit [15:0] rn);
            int r;
            chain_result_t res;
            r = $signed(r_raw);
            if (r > 256) r = 256;
            if (r < -256) r = -256;
            case (cmd)
                CMD_LEARN:   do_learn(note);
                CMD_ADVANCE: do_advance(r, rp, rs, rn);
                CMD_NEAREST: go_nearest(note);
                CMD_FORGET:  do_forget();
                CMD_CLEAR:   wipe();
                default: ;
            endcase
            res.has  = cur_ok;
            res.note = cur_ok ? slot_note[cur_slot] : 7'd0;
            pending = {pending, res};
        endfunction

        function void check_result(bit [6:0] note, bit has);
            chain_result_t exp_res;
            if (pending.size() == 0) begin
                $display("%0t unexpected result: expected none, actual note %0d has %0d",
                         $time, note, has);
                errors++;
                return;
            end
            exp_res = pending.pop_front();
            if (exp_res.note != note) begin
                $display("%0t current_note mismatch: expected %0d, actual %0d",
                         $time, exp_res.note, note);
                errors++;
            end
            if (exp_res.has != has) begin
                $display("%0t has_current mismatch: expected %0d, actual %0d",
                         $time, exp_res.has, has);
                errors++;
            end
        endfunction
    endclass

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    logic [2:0]        s_cmd;
    logic [6:0]        s_note;
    logic signed [9:0] s_randomness;
    logic [15:0]       s_rand_pick;
    logic [15:0]       s_rand_skip;
    logic [15:0]       s_rand_node;
    logic              m_valid;
    logic              m_ready;
    logic [6:0]        m_current_note;
    logic              m_has_current;

    chain_scoreboard chain_sb;
    bit  idle_on;
    bit  hold_req;
    int  sent_count;
    int  quiet_cycles = 0;

    markov_note_chain_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_cmd(s_cmd), .s_note(s_note), .s_randomness(s_randomness),
        .s_rand_pick(s_rand_pick), .s_rand_skip(s_rand_skip), .s_rand_node(s_rand_node),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_current_note(m_current_note), .m_has_current(m_has_current)
    );

    initial begin
        aclk = 0;
        forever #1 aclk = ~aclk;
    end

    // offer one request and wait for it; valid stays high unless a gap follows
    task automatic send_req(bit [2:0] cmd, bit [6:0] note, bit [9:0] r,
                            bit [15:0] rp, bit [15:0] rs, bit [15:0] rn);
        s_valid      <= 1'b1;
        s_cmd        <= cmd;
        s_note       <= note;
        s_randomness <= r;
        s_rand_pick  <= rp;
        s_rand_skip  <= rs;
        s_rand_node  <= rn;
        do @(posedge aclk); while (!s_ready);
        chain_sb.note_request(cmd, note, r, rp, rs, rn);
        sent_count++;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
    endtask

    task automatic send_cmd(bit [2:0] cmd, bit [6:0] note);
        send_req(cmd, note, 10'($urandom_range(0, 1023)), 16'($urandom), 16'($urandom),
                 16'($urandom));
    endtask

    // advance with randomness spread over the whole field, biased into +-256
    task automatic send_advance();
        bit [9:0] r;
        if ($urandom_range(0, 4) == 0) r = 10'($urandom_range(0, 1023));
        else r = 10'($signed($urandom_range(0, 512)) - 256);
        send_req(CMD_ADVANCE, 7'($urandom), r, 16'($urandom), 16'($urandom), 16'($urandom));
    endtask

    // receiver: random stall bursts, plus one long hold when requested
    initial begin
        m_ready <= 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (400) @(posedge aclk);
                hold_req = 0;
            end else if (!idle_on) begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end else begin
                m_ready <= ($urandom_range(0, 2) != 0);
                repeat ($urandom_range(1, 8)) @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) chain_sb.check_result(m_current_note, m_has_current);
    end

    // watchdog on cycles with no handshake on either channel
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 200000) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        int pool[10];
        int psize;
        int base;
        int kind;
        chain_sb = new();
        chain_sb.wipe();
        chain_sb.errors = 0;
        idle_on      = 1;
        hold_req     = 0;
        sent_count   = 0;
        aresetn      <= 1'b0;
        s_valid      <= 1'b0;
        s_cmd        <= CMD_CLEAR;
        s_note       <= '0;
        s_randomness <= '0;
        s_rand_pick  <= '0;
        s_rand_skip  <= '0;
        s_rand_node  <= '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty chain, repeated learn, extremes, saturation, unused codes
        send_req(CMD_ADVANCE, 0, 0, 0, 0, 0);
        send_req(CMD_NEAREST, 64, 0, 0, 0, 0);
        send_req(CMD_FORGET, 0, 0, 0, 0, 0);
        send_req(CMD_LEARN, 0, 0, 0, 0, 0);
        send_req(CMD_LEARN, 0, 0, 0, 0, 0);
        send_req(CMD_ADVANCE, 0, 10'sd256, 16'hffff, 0, 16'hffff);
        send_req(CMD_LEARN, 127, 0, 0, 0, 0);
        send_req(CMD_LEARN, 0, 0, 0, 0, 0);
        send_req(CMD_LEARN, 127, 0, 0, 0, 0);
        send_req(CMD_LEARN, 64, 0, 0, 0, 0);
        send_req(CMD_ADVANCE, 0, -10'sd256, 16'hffff, 16'hffff, 0);
        send_req(CMD_ADVANCE, 0, 10'sd511, 16'hffff, 0, 16'hffff);
        send_req(CMD_ADVANCE, 0, -10'sd512, 0, 16'hffff, 0);
        send_req(CMD_ADVANCE, 0, -10'sd231, 16'hffff, 16'hffff, 0);
        send_req(CMD_ADVANCE, 0, 10'sd129, 0, 0, 16'hffff);
        send_req(3'd5, 7'h7f, 10'h3ff, 16'hffff, 16'hffff, 16'hffff);
        send_req(3'd6, 0, 0, 0, 0, 0);
        send_req(3'd7, 0, 0, 0, 0, 0);
        send_req(CMD_NEAREST, 127, 0, 0, 0, 0);
        send_req(CMD_NEAREST, 0, 0, 0, 0, 0);
        send_req(CMD_FORGET, 0, 0, 0, 0, 0);
        send_req(CMD_FORGET, 0, 0, 0, 0, 0);
        send_req(CMD_FORGET, 0, 0, 0, 0, 0);
        send_req(CMD_ADVANCE, 0, 0, 0, 0, 0);
        send_req(CMD_CLEAR, 0, 0, 0, 0, 0);

        // overfill one edge list from a hub note
        for (int i = 1; i <= 18; i++) begin
            send_req(CMD_LEARN, 60, 0, 0, 0, 0);
            send_req(CMD_LEARN, 7'(i), 0, 0, 0, 0);
        end
        send_req(CMD_LEARN, 60, 0, 0, 0, 0);
        repeat (6) send_advance();
        hold_req = 1;
        repeat (10) send_advance();
        send_req(CMD_CLEAR, 0, 0, 0, 0, 0);

        // fill every node slot, walk it, forget once at full size
        for (int i = 0; i < 128; i++) send_req(CMD_LEARN, 7'(i), 0, 0, 0, 0);
        repeat (8) send_advance();
        send_cmd(CMD_FORGET, 0);
        send_cmd(CMD_CLEAR, 0);

        // random sequences, mostly well-formed learn runs over a small pool
        while (sent_count < 1650) begin
            if (sent_count > 1500) idle_on = 0;
            if (chain_sb.slot_count > 40) send_cmd(CMD_CLEAR, 0);
            kind = $urandom_range(0, 99);
            if (kind < 45) begin
                psize = $urandom_range(2, 10);
                base  = $urandom_range(0, 127);
                foreach (pool[i]) pool[i] = (base + $urandom_range(0, 15)) % 128;
                if ($urandom_range(0, 3) == 0) pool[0] = 0;
                if ($urandom_range(0, 3) == 0) pool[1] = 127;
                repeat ($urandom_range(3, 14))
                    send_cmd(CMD_LEARN, 7'(pool[$urandom_range(0, psize - 1)]));
            end else if (kind < 80) begin
                repeat ($urandom_range(2, 8)) send_advance();
            end else if (kind < 88) begin
                send_cmd(CMD_NEAREST, 7'($urandom));
            end else if (kind < 95) begin
                send_cmd(CMD_FORGET, 7'($urandom));
            end else if (kind < 97) begin
                send_cmd(CMD_CLEAR, 7'($urandom));
            end else begin
                send_cmd(3'($urandom_range(5, 7)), 7'($urandom));
            end
        end
        s_valid <= 1'b0;

        while (chain_sb.pending.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (chain_sb.errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
